[rtl/mexp_pkg.sv]
`default_nettype none
package mexp_pkg;

	localparam int DEF_EXP_WIDTH = 32;
	localparam int DEF_MOD_WIDTH = 31;
	localparam int IN_WIDTH      = 32;
	localparam int OUT_WIDTH     = 31;
	localparam int APB_DW        = 32;
	localparam int APB_AW        = 3;

	localparam logic [31:0] MODULUS_RESET = 32'd1000000000;
	localparam logic        REG_MODULUS   = 1'b0;

	typedef enum logic [1:0] {
		FIN_ZERO,
		FIN_ONE,
		FIN_ACC
	} fin_sel_t;

	typedef struct packed {
		logic     load;
		logic     red_mul;
		logic     red_step;
		logic     set_base;
		logic     iter;
		logic     fin;
		fin_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic mod_zero;
		logic exp_zero;
		logic red_last;
	} stat_t;

endpackage
`default_nettype wire

[rtl/modular_exponentiation.sv]
// Computes base_value ** exponent_value mod modulus by right-to-left square-and-multiply.
// A transfer is taken when start is high and busy is low; the answer appears on
// power_result with done high for exactly one cycle, and the receiver cannot stall it,
// so capture it on that cycle. busy stays high until done. The bit-serial remainder
// units reduce the R-bit product one bit a cycle, with R = max(2*MOD_WIDTH, 32) (62 by
// default), and the square-and-multiply loop runs once per exponent bit up to the highest
// set one. A zero exponent or a zero modulus finishes at the check, with no reduction.
// Write the modulus only while idle.
`default_nettype none
module modular_exponentiation import mexp_pkg::*; #(
	parameter int EXP_WIDTH = DEF_EXP_WIDTH,
	parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	output logic                       done,
	input  wire logic [IN_WIDTH-1:0]   base_value,
	input  wire logic [IN_WIDTH-1:0]   exponent_value,
	output logic      [OUT_WIDTH-1:0]  power_result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic      [APB_DW-1:0]     prdata,
	output logic                       pready
);

	cmd_t                 cmd;
	stat_t                stat;
	logic [MOD_WIDTH-1:0] modulus_q;
	logic                 reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = 1'(paddr >> 2);
	assign wr_en   = psel & penable & pwrite & pready;
	assign prdata  = (reg_idx == REG_MODULUS) ? APB_DW'(modulus_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_WIDTH'(MODULUS_RESET);
		end else if (wr_en && reg_idx == REG_MODULUS) begin
			modulus_q <= MOD_WIDTH'(pwdata);
		end
	end

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mexp_dp #(.EXP_WIDTH(EXP_WIDTH), .MOD_WIDTH(MOD_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus        (modulus_q),
		.stat           (stat),
		.power_result   (power_result)
	);

endmodule
`default_nettype wire

[rtl/mexp_red.sv]
`default_nettype none
module mexp_red import mexp_pkg::*; #(
	parameter int MOD_WIDTH = DEF_MOD_WIDTH,
	parameter int RED_W     = 2 * DEF_MOD_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic                 step,
	input  wire logic [RED_W-1:0]     dividend,
	input  wire logic [MOD_WIDTH-1:0] modulus,
	output logic      [MOD_WIDTH-1:0] rem
);

	logic [RED_W-1:0]     div_q;
	logic [MOD_WIDTH-1:0] rem_q;
	logic [MOD_WIDTH:0]   trial;
	logic [MOD_WIDTH:0]   diff;

	assign trial = {rem_q, div_q[RED_W-1]};
	assign diff  = trial - {1'b0, modulus};
	assign rem   = rem_q;

	always_ff @(posedge clk) begin
		if (load) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			div_q <= div_q << 1;
			if (trial >= {1'b0, modulus}) begin
				rem_q <= diff[MOD_WIDTH-1:0];
			end else begin
				rem_q <= trial[MOD_WIDTH-1:0];
			end
		end
	end

endmodule
`default_nettype wire

[rtl/mexp_dp.sv]
`default_nettype none
module mexp_dp import mexp_pkg::*; #(
	parameter int EXP_WIDTH = DEF_EXP_WIDTH,
	parameter int MOD_WIDTH = DEF_MOD_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	input  wire logic [IN_WIDTH-1:0]  base_value,
	input  wire logic [IN_WIDTH-1:0]  exponent_value,
	input  wire logic [MOD_WIDTH-1:0] modulus,
	output stat_t                     stat,
	output logic      [OUT_WIDTH-1:0] power_result
);

	localparam int EW    = (EXP_WIDTH > IN_WIDTH) ? IN_WIDTH : EXP_WIDTH;
	localparam int RED_W = (2 * MOD_WIDTH > IN_WIDTH) ? 2 * MOD_WIDTH : IN_WIDTH;
	localparam int CNT_W = $clog2(RED_W);

	logic [MOD_WIDTH-1:0]   base_q;
	logic [MOD_WIDTH-1:0]   acc_q;
	logic [EW-1:0]          exp_q;
	logic [MOD_WIDTH-1:0]   result_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [2*MOD_WIDTH-1:0] sq;
	logic [2*MOD_WIDTH-1:0] ab;
	logic [RED_W-1:0]       div_a;
	logic [RED_W-1:0]       div_b;
	logic [MOD_WIDTH-1:0]   rem_a;
	logic [MOD_WIDTH-1:0]   rem_b;
	logic                   red_load;

	assign sq       = base_q * base_q;
	assign ab       = acc_q * base_q;
	assign div_a    = cmd.load ? RED_W'(base_value) : RED_W'(sq);
	assign div_b    = RED_W'(ab);
	assign red_load = cmd.load | cmd.red_mul;

	mexp_red #(.MOD_WIDTH(MOD_WIDTH), .RED_W(RED_W)) u_red_a (
		.clk      (clk),
		.load     (red_load),
		.step     (cmd.red_step),
		.dividend (div_a),
		.modulus  (modulus),
		.rem      (rem_a)
	);

	mexp_red #(.MOD_WIDTH(MOD_WIDTH), .RED_W(RED_W)) u_red_b (
		.clk      (clk),
		.load     (cmd.red_mul),
		.step     (cmd.red_step),
		.dividend (div_b),
		.modulus  (modulus),
		.rem      (rem_b)
	);

	assign stat.mod_zero = (modulus == '0);
	assign stat.exp_zero = (exp_q == '0);
	assign stat.red_last = (cnt_q == CNT_W'(RED_W - 1));
	assign power_result  = OUT_WIDTH'(result_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (red_load) begin
			cnt_q <= '0;
		end else if (cmd.red_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			exp_q <= EW'(exponent_value);
			acc_q <= (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
		end
		if (cmd.set_base) begin
			base_q <= rem_a;
		end
		if (cmd.iter) begin
			base_q <= rem_a;
			exp_q  <= exp_q >> 1;
			if (exp_q[0]) begin
				acc_q <= rem_b;
			end
		end
		if (cmd.fin) begin
			case (cmd.sel)
				FIN_ZERO: result_q <= '0;
				FIN_ONE:  result_q <= MOD_WIDTH'(1);
				FIN_ACC:  result_q <= acc_q;
				default:  result_q <= '0;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/mexp_ctrl.sv]
`default_nettype none
module mexp_ctrl import mexp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire stat_t stat,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_REDB,
		S_SETB,
		S_LOOP,
		S_RED,
		S_ITER
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd = '0;
		cmd.sel = FIN_ACC;
		case (state_q)
			S_IDLE:  cmd.load = start;
			S_CHECK: begin
				if (stat.mod_zero) begin
					cmd.fin = 1'b1;
					cmd.sel = FIN_ZERO;
				end else if (stat.exp_zero) begin
					cmd.fin = 1'b1;
					cmd.sel = FIN_ONE;
				end
			end
			S_REDB:  cmd.red_step = 1'b1;
			S_SETB:  cmd.set_base = 1'b1;
			S_LOOP: begin
				if (stat.exp_zero) begin
					cmd.fin = 1'b1;
				end else begin
					cmd.red_mul = 1'b1;
				end
			end
			S_RED:   cmd.red_step = 1'b1;
			S_ITER:  cmd.iter = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.mod_zero || stat.exp_zero) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_REDB;
					end
				end
				S_REDB: begin
					if (stat.red_last) begin
						state_q <= S_SETB;
					end
				end
				S_SETB:  state_q <= S_LOOP;
				S_LOOP: begin
					if (stat.exp_zero) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (stat.red_last) begin
						state_q <= S_ITER;
					end
				end
				S_ITER:  state_q <= S_LOOP;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[tb/mexp_checker.sv]
module mexp_checker import mexp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic                 done,
	input  wire logic [IN_WIDTH-1:0]  base_value,
	input  wire logic [IN_WIDTH-1:0]  exponent_value,
	input  wire logic [OUT_WIDTH-1:0] power_result,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [APB_AW-1:0]    paddr,
	input  wire logic [APB_DW-1:0]    pwdata,
	input  wire logic [APB_DW-1:0]    prdata,
	input  wire logic                 pready,
	output int                        mismatches,
	output int                        outstanding,
	output int                        checked
);

	localparam logic [APB_AW-1:0] MODULUS_ADDR = APB_AW'({REG_MODULUS, 2'b00});
	localparam int REPORT_MAX = 10;

	logic [DEF_MOD_WIDTH-1:0] modulus_copy;
	logic [OUT_WIDTH-1:0]     power_queue[$];

	function automatic logic [OUT_WIDTH-1:0] expected_power(
		input logic [IN_WIDTH-1:0]      base_in,
		input logic [IN_WIDTH-1:0]      exp_in,
		input logic [DEF_MOD_WIDTH-1:0] modv
	);
		logic [63:0] acc;
		logic [63:0] sq;
		logic [63:0] m;
		logic [63:0] rest;
		int k;
		if (modv == '0)
			return '0;
		if (exp_in == '0)
			return OUT_WIDTH'(1);
		m = 64'(modv);
		sq = 64'(base_in) % m;
		acc = 64'd1 % m;
		rest = 64'(exp_in);
		for (k = 0; k < DEF_EXP_WIDTH && rest != 0; k++) begin
			if (rest[0])
				acc = (acc * sq) % m;
			rest = rest >> 1;
			sq = (sq * sq) % m;
		end
		return acc[OUT_WIDTH-1:0];
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		if (mismatches < REPORT_MAX)
			$display("%0t mismatch on %s: expected %0d got %0d", $time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_copy = MODULUS_RESET[DEF_MOD_WIDTH-1:0];
			power_queue.delete();
			mismatches = 0;
			checked = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pready && pwrite && paddr == MODULUS_ADDR)
				modulus_copy = pwdata[DEF_MOD_WIDTH-1:0];
			if (psel && penable && pready && !pwrite && paddr == MODULUS_ADDR &&
			    prdata !== APB_DW'(modulus_copy))
				report("modulus readback", 64'(modulus_copy), 64'(prdata));
			if (done === 1'b1) begin
				if (power_queue.size() == 0) begin
					report("unexpected power_result", 64'd0, 64'(power_result));
				end else begin
					if (power_result !== power_queue[0])
						report("power_result", 64'(power_queue[0]), 64'(power_result));
					void'(power_queue.pop_front());
					checked++;
				end
			end
			if (start && !busy)
				power_queue.push_back(expected_power(base_value, exponent_value, modulus_copy));
			outstanding = power_queue.size();
		end
	end

endmodule

[tb/tb_top.sv]
module tb_top;
	import mexp_pkg::*;

	localparam logic [APB_AW-1:0] MODULUS_ADDR = APB_AW'({REG_MODULUS, 2'b00});
	localparam int QUIET_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_ITEMS  = 90;
	localparam int IDLE_LIGHT   = 37;
	localparam int IDLE_HEAVY   = 69;
	localparam int IDLE_NONE    = 0;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 done;
	logic [IN_WIDTH-1:0]  base_value;
	logic [IN_WIDTH-1:0]  exponent_value;
	logic [OUT_WIDTH-1:0] power_result;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	int mismatches;
	int outstanding;
	int checked;
	int items_sent;
	int modulus_writes;
	int quiet_cycles;
	logic [DEF_MOD_WIDTH-1:0] cur_mod;

	modular_exponentiation DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.power_result  (power_result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	mexp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.power_result  (power_result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done === 1'b1 || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(input logic [IN_WIDTH-1:0] b, input logic [IN_WIDTH-1:0] e,
	                         input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		base_value <= b;
		exponent_value <= e;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (outstanding != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= MODULUS_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_modulus(input logic [APB_DW-1:0] v);
		wait_idle();
		apb_transfer(1'b1, v);
		apb_transfer(1'b0, '0);
		cur_mod = v[DEF_MOD_WIDTH-1:0];
		modulus_writes++;
	endtask

	function automatic logic [APB_DW-1:0] pick_modulus();
		case ($urandom_range(0, 5))
			0: return APB_DW'($urandom_range(1, 16));
			1: return APB_DW'(32'h7FFF_FFFF);
			2: return $urandom;
			3: return APB_DW'($urandom_range(2, 1000));
			4: return {1'b0, 1'b1, 30'($urandom)};
			default: return APB_DW'(32'd1 << $urandom_range(0, 30));
		endcase
	endfunction

	function automatic logic [IN_WIDTH-1:0] pick_base();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return IN_WIDTH'(1);
			2: return '1;
			3: return IN_WIDTH'(cur_mod) - IN_WIDTH'(1);
			4: return IN_WIDTH'(cur_mod) * IN_WIDTH'($urandom_range(0, 3));
			5: return IN_WIDTH'(cur_mod) + IN_WIDTH'($urandom_range(0, 9));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IN_WIDTH-1:0] pick_exponent();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 3)
			return $urandom;
		if (sel <= 6)
			return IN_WIDTH'($urandom_range(0, 15));
		if (sel <= 8)
			return $urandom >> $urandom_range(0, 31);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return IN_WIDTH'(1);
			2: return '1;
			default: return IN_WIDTH'(32'h8000_0000);
		endcase
	endfunction

	task automatic run_random(input int idle_pct);
		int i;
		for (i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 30 == 0)
				set_modulus(pick_modulus());
			send_item(pick_base(), pick_exponent(), idle_pct);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		base_value = '0;
		exponent_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quiet_cycles = 0;
		items_sent = 0;
		modulus_writes = 0;
		cur_mod = MODULUS_RESET[DEF_MOD_WIDTH-1:0];
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset modulus, checked by readback
		apb_transfer(1'b0, '0);
		send_item(32'h0, 32'h0, IDLE_LIGHT);
		send_item(32'h0, 32'd7, IDLE_LIGHT);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_LIGHT);
		send_item(32'hFFFF_FFFF, 32'h0, IDLE_LIGHT);
		send_item(32'h1, 32'hFFFF_FFFF, IDLE_LIGHT);
		send_item(32'h2, 32'd30, IDLE_LIGHT);
		send_item(32'd1000000000, 32'd3, IDLE_LIGHT);
		send_item(32'h3, 32'h8000_0000, IDLE_LIGHT);

		set_modulus(32'd1);
		send_item(32'd5, 32'h0, IDLE_LIGHT);
		send_item(32'd5, 32'd3, IDLE_LIGHT);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_LIGHT);

		set_modulus(32'h7FFF_FFFF);
		send_item(32'h7FFF_FFFE, 32'd2, IDLE_LIGHT);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_LIGHT);
		send_item(32'h8000_0000, 32'd1, IDLE_LIGHT);

		// upper bit is dropped, leaving a zero modulus
		set_modulus(32'h8000_0000);
		send_item(32'd7, 32'h0, IDLE_LIGHT);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_LIGHT);

		set_modulus(32'd2);
		send_item(32'd3, 32'd5, IDLE_LIGHT);
		send_item(32'd4, 32'd5, IDLE_LIGHT);

		run_random(IDLE_LIGHT);
		run_random(IDLE_HEAVY);
		run_random(IDLE_NONE);

		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d exponentiation requests, checked %0d results, %0d mismatches.",
		         items_sent, checked, mismatches);
		$display("Covered %0d modulus settings including one, zero and the 31-bit maximum.",
		         modulus_writes + 1);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
